// File: src/assert_macros.svh
// Assertion macros used by the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

// Condition that must never hold.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: src/rbfa_pkg.sv
// Package for the ring buffer fragment allocator: word types and operation codes.
package rbfa_pkg;

    localparam int RING_ADDR_BITS_DEFAULT = 12;

    localparam logic [1:0] FUNC_ACQUIRE  = 2'd0;
    localparam logic [1:0] FUNC_RELEASE  = 2'd1;
    localparam logic [1:0] FUNC_LEFTOVER = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] request_length;
        logic [15:0] span_front;
        logic [11:0] span_rear;
        logic [11:0] new_tail;
        logic        has_data;
    } in_word_t;

    typedef struct packed {
        logic [12:0] granted_length;
        logic [11:0] fragment_front;
        logic [11:0] fragment_rear;
        logic        accepted;
        logic [12:0] free_contiguous;
    } out_word_t;

endpackage

// File: src/rbfa_alloc_core.sv
// Pointer state and single-pass update logic of the fragment allocator.
`include "assert_macros.svh"

module rbfa_alloc_core #(
    parameter int RING_ADDR_BITS = rbfa_pkg::RING_ADDR_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  rbfa_pkg::in_word_t  word,
    output rbfa_pkg::out_word_t result
);

    localparam int AW = RING_ADDR_BITS;

    typedef logic [AW-1:0] ptr_t;
    typedef logic [AW:0]   len_t;

    localparam len_t RING_SIZE = {1'b1, {AW{1'b0}}};

    ptr_t head_reg, head_next;
    ptr_t tail_reg, tail_next;
    logic last_reg, last_next;

    function automatic len_t free_of(input ptr_t head, input ptr_t tail, input logic last);
        len_t f;
        if (tail == head)
            f = last ? '0 : RING_SIZE - {1'b0, tail};
        else if (tail < head)
            f = {1'b0, head} - {1'b0, tail};
        else
            f = RING_SIZE - {1'b0, tail};
        return f;
    endfunction

    function automatic len_t used_of(input ptr_t head, input ptr_t tail, input logic last);
        len_t u;
        if (tail == head)
            u = last ? RING_SIZE : '0;
        else if (tail > head)
            u = {1'b0, tail} - {1'b0, head};
        else
            u = RING_SIZE - {1'b0, head} + {1'b0, tail};
        return u;
    endfunction

    len_t        space;
    len_t        used;
    logic [15:0] space16;
    logic [15:0] granted16;
    ptr_t        grant_ptr;
    ptr_t        acq_rear;
    ptr_t        acq_tail;
    logic [15:0] head16;
    logic [15:0] rear16;
    logic [15:0] ntail16;
    logic [15:0] span_diff;
    len_t        span_len;
    ptr_t        rel_head;
    logic        rel_ok;
    len_t        free_after;
    logic [31:0] granted32;
    logic [31:0] front32;
    logic [31:0] rear32;
    logic [31:0] free32;
    logic        acc;
    logic        acq_fire;
    logic        rel_fire;

    assign space     = free_of(head_reg, tail_reg, last_reg);
    assign used      = used_of(head_reg, tail_reg, last_reg);
    assign space16   = 16'(space);
    assign granted16 = (word.request_length < space16) ? word.request_length : space16;
    assign grant_ptr = granted16[AW-1:0];
    assign acq_rear  = tail_reg + grant_ptr - ptr_t'(1);
    assign acq_tail  = tail_reg + grant_ptr;

    assign head16    = 16'(head_reg);
    assign rear16    = 16'(word.span_rear);
    assign ntail16   = 16'(word.new_tail);
    assign span_diff = rear16 - word.span_front;
    assign span_len  = {1'b0, span_diff[AW-1:0]} + len_t'(1);
    assign rel_head  = rear16[AW-1:0] + ptr_t'(1);
    assign rel_ok    = (word.span_front == head16) && (span_len <= used);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        last_next = last_reg;
        granted32 = '0;
        front32   = '0;
        rear32    = '0;
        acc       = 1'b0;
        unique case (word.func)
            rbfa_pkg::FUNC_ACQUIRE:
            begin
                tail_next = acq_tail;
                last_next = 1'b1;
                granted32 = 32'(granted16);
                front32   = 32'(tail_reg);
                rear32    = 32'(acq_rear);
                acc       = 1'b1;
            end
            rbfa_pkg::FUNC_RELEASE:
            begin
                if (rel_ok)
                begin
                    head_next = rel_head;
                    last_next = 1'b0;
                    acc       = 1'b1;
                end
            end
            rbfa_pkg::FUNC_LEFTOVER:
            begin
                tail_next = ntail16[AW-1:0];
                if (ntail16[AW-1:0] == head_reg)
                    last_next = word.has_data;
                acc = 1'b1;
            end
            default:
            begin
                // unused code: no change, not accepted
            end
        endcase
    end

    assign free_after = free_of(head_next, tail_next, last_next);
    assign free32     = 32'(free_after);

    assign result.granted_length  = granted32[12:0];
    assign result.fragment_front  = front32[11:0];
    assign result.fragment_rear   = rear32[11:0];
    assign result.accepted        = acc;
    assign result.free_contiguous = free32[12:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            last_reg <= 1'b0;
        end
        else if (fire)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            last_reg <= last_next;
        end
    end

    assign acq_fire = fire && (word.func == rbfa_pkg::FUNC_ACQUIRE);
    assign rel_fire = fire && (word.func == rbfa_pkg::FUNC_RELEASE);

    // rejected release must not touch the pointers or the flag
    `ASSERT_NEXT(a_reject_holds, clk, rst_n, rel_fire && !acc, $stable({head_reg, tail_reg, last_reg}))
    // grant never exceeds the request
    `ASSERT_IMPLY(a_grant_bounded, clk, rst_n, acq_fire, 16'(result.granted_length) <= word.request_length)
    // any acquire, even zero length, marks the ring as last acquired
    `ASSERT_NEXT(a_acquire_flag, clk, rst_n, acq_fire, last_reg)

endmodule

// File: src/ring_buffer_fragment_allocator.sv
// Top level of the ring buffer fragment allocator: input and result registers around the core.
//
// Bookkeeping for a ring of 2^RING_ADDR_BITS bytes: head, tail and a flag
// telling a full ring from an empty one. The data store is elsewhere.
// Request channel (req_valid/req_ready/req_word) takes one command word:
// acquire, release, or release leftover (tail moved back).
// Response channel (rsp_valid/rsp_ready/rsp_word) returns exactly one word
// per command, in order: grant length and offsets, accepted flag and the
// contiguous free space after the command.
// Path: a word accepted into the input register is worked through the core
// by combinational logic and lands in the response register, from which the
// receiver takes it.
// Throughput: one command per cycle while the receiver takes responses. The
// pointer update is a single combinational pass of compares and subtracts.
// When the receiver stalls, the response register holds its word, the input
// register fills, and req_ready drops until the response is taken.
// Reset (rst_n low, asynchronous) empties the ring: head = tail = 0, flag
// clear, both registers empty.

module ring_buffer_fragment_allocator #(
    parameter int RING_ADDR_BITS = rbfa_pkg::RING_ADDR_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  rbfa_pkg::in_word_t  req_word,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rbfa_pkg::out_word_t rsp_word
);

    // input stage
    logic                s1_valid_reg, s1_valid_next;
    rbfa_pkg::in_word_t  s1_word_reg;

    // response stage
    logic                rsp_valid_reg, rsp_valid_next;
    rbfa_pkg::out_word_t rsp_word_reg;

    logic                s1_advance;
    rbfa_pkg::out_word_t core_result;

    // the input word moves on when the response slot is free or being drained
    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s1_advance;

    rbfa_alloc_core #(
        .RING_ADDR_BITS (RING_ADDR_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_advance),
        .word   (s1_word_reg),
        .result (core_result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_valid && req_ready)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (s1_advance)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            s1_word_reg <= req_word;
        if (s1_advance)
            rsp_word_reg <= core_result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// File: sim/ring_buffer_fragment_allocator_tb.sv
// Self-checking testbench for the ring buffer fragment allocator.
`timescale 1ns / 100ps

module ring_buffer_fragment_allocator_tb;

    // The block is built with its default ring size, and so is the shadow below.
    localparam int AW         = rbfa_pkg::RING_ADDR_BITS_DEFAULT;
    localparam int RING_BYTES = 1 << AW;
    localparam int RING_MASK  = RING_BYTES - 1;

    // The fourth func code has no meaning. The block must reject it and keep its state.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    rbfa_pkg::in_word_t  req_word  = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rbfa_pkg::out_word_t rsp_word;

    // Percentages of cycles in which each side holds off. Changed per phase.
    int send_idle_pct = 0;
    int take_idle_pct = 0;

    int mismatches = 0;

    // Shadow copy of the ring pointers. It is advanced when a command word is
    // accepted, so it always matches the state that the next word will see.
    int ring_head   = 0;
    int ring_tail   = 0;
    bit ring_loaded = 1'b0;   // set by an acquire or a leftover with has_data: head == tail means full

    // Expected response words, oldest first.
    rbfa_pkg::out_word_t pending_rsp[$];

    ring_buffer_fragment_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    always #5 clk = ~clk;

    // Contiguous free bytes from the tail up to the head or the ring's end.
    function automatic int contig_free_bytes();
        if (ring_tail == ring_head)
            return ring_loaded ? 0 : RING_BYTES - ring_tail;
        if (ring_tail < ring_head)
            return ring_head - ring_tail;
        return RING_BYTES - ring_tail;
    endfunction

    // Bytes that lie between the head and the tail.
    function automatic int used_bytes();
        if (ring_tail == ring_head)
            return ring_loaded ? RING_BYTES : 0;
        if (ring_tail > ring_head)
            return ring_tail - ring_head;
        return RING_BYTES - ring_head + ring_tail;
    endfunction

    // Apply one command to the shadow pointers and return the response word
    // that the block should give for it.
    function automatic rbfa_pkg::out_word_t apply_command(rbfa_pkg::in_word_t cmd);
        rbfa_pkg::out_word_t rsp;
        int                  space;
        int                  grant;
        int                  rear;
        int                  span;
        rsp = '0;
        case (cmd.func)
            rbfa_pkg::FUNC_ACQUIRE:
            begin
                space = contig_free_bytes();
                grant = (int'(cmd.request_length) < space) ? int'(cmd.request_length) : space;
                // A zero grant still reports a rear of tail - 1 and marks the ring loaded.
                rear  = (ring_tail + grant + RING_MASK) & RING_MASK;
                rsp.granted_length = 13'(grant);
                rsp.fragment_front = 12'(ring_tail);
                rsp.fragment_rear  = 12'(rear);
                rsp.accepted       = 1'b1;
                ring_tail   = (rear + 1) & RING_MASK;
                ring_loaded = 1'b1;
            end
            rbfa_pkg::FUNC_RELEASE:
            begin
                // The front is compared at full width, so set upper bits reject the release.
                if (int'(cmd.span_front) == ring_head)
                begin
                    span = ((int'(cmd.span_rear) - int'(cmd.span_front)) & RING_MASK) + 1;
                    if (span <= used_bytes())
                    begin
                        ring_head    = (int'(cmd.span_rear) + 1) & RING_MASK;
                        ring_loaded  = 1'b0;
                        rsp.accepted = 1'b1;
                    end
                end
            end
            rbfa_pkg::FUNC_LEFTOVER:
            begin
                ring_tail = int'(cmd.new_tail) & RING_MASK;
                // The flag only matters, and only moves, when the tail lands on the head.
                if (ring_tail == ring_head)
                    ring_loaded = cmd.has_data;
                rsp.accepted = 1'b1;
            end
            default:
            begin
            end
        endcase
        rsp.free_contiguous = 13'(contig_free_bytes());
        return rsp;
    endfunction

    function automatic rbfa_pkg::in_word_t cmd_word(logic [1:0] func, int req, int front,
                                                    int rear, int ntail, bit full);
        rbfa_pkg::in_word_t w;
        w.func           = func;
        w.request_length = 16'(req);
        w.span_front     = 16'(front);
        w.span_rear      = 12'(rear);
        w.new_tail       = 12'(ntail);
        w.has_data       = full;
        return w;
    endfunction

    // Offer one command word. Called at a rising edge and returns at the edge
    // that accepted it. The valid gets a single update per step: it is either
    // held high for this word or dropped for an idle step.
    task automatic send_word(input rbfa_pkg::in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rsp.push_back(apply_command(w));
    endtask

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= take_idle_pct);

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted response word with the oldest expectation.
    always @(posedge clk)
    begin : rsp_check
        rbfa_pkg::out_word_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response word %h with none expected", $time, rsp_word);
                mismatches++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("granted_length", want.granted_length, rsp_word.granted_length);
                check_field("fragment_front", want.fragment_front, rsp_word.fragment_front);
                check_field("fragment_rear", want.fragment_rear, rsp_word.fragment_rear);
                check_field("accepted", want.accepted, rsp_word.accepted);
                check_field("free_contiguous", want.free_contiguous,
                            rsp_word.free_contiguous);
            end
        end
    end

    // Grant limits. Zero-length acquire on an empty ring makes it read full;
    // oversized request; acquire on a full ring.
    task automatic test_acquire_limits();
        send_word(cmd_word(rbfa_pkg::FUNC_ACQUIRE, 0, 0, 0, 0, 1'b0));
        send_word(cmd_word(rbfa_pkg::FUNC_RELEASE, 0, 0, 4095, 0, 1'b0));     // whole ring back
        send_word(cmd_word(rbfa_pkg::FUNC_ACQUIRE, 16'hFFFF, 0, 0, 0, 1'b0)); // clipped
        send_word(cmd_word(rbfa_pkg::FUNC_ACQUIRE, 5, 0, 0, 0, 1'b0));        // full: nothing
    endtask

    // Release rules. Front must equal the head at full width. Span up to the
    // used space is taken, and a span one byte longer is refused.
    task automatic test_release_checks();
        send_word(cmd_word(rbfa_pkg::FUNC_RELEASE, 0, 1, 10, 0, 1'b0));        // not at head
        send_word(cmd_word(rbfa_pkg::FUNC_RELEASE, 0, 16'h1000, 10, 0, 1'b0)); // low bits only
        send_word(cmd_word(rbfa_pkg::FUNC_RELEASE, 0, 0, 99, 0, 1'b0));
        send_word(cmd_word(rbfa_pkg::FUNC_ACQUIRE, 200, 0, 0, 0, 1'b0));       // limited by head
        send_word(cmd_word(rbfa_pkg::FUNC_RELEASE, 0, 100, 99, 0, 1'b0));      // full released
        send_word(cmd_word(rbfa_pkg::FUNC_RELEASE, 0, 100, 100, 0, 1'b0));     // empty: refused
        send_word(cmd_word(rbfa_pkg::FUNC_ACQUIRE, 4000, 0, 0, 0, 1'b0));      // ring end limit
    endtask

    // Tail moved back, onto the head both ways, and wrap of the tail at the ring's end.
    task automatic test_leftover_moves();
        send_word(cmd_word(rbfa_pkg::FUNC_LEFTOVER, 0, 0, 0, 4000, 1'b0));
        send_word(cmd_word(rbfa_pkg::FUNC_LEFTOVER, 0, 0, 0, 100, 1'b1));   // meets head: full
        send_word(cmd_word(rbfa_pkg::FUNC_LEFTOVER, 0, 0, 0, 100, 1'b0));   // meets head: empty
        send_word(cmd_word(rbfa_pkg::FUNC_ACQUIRE, 1, 0, 0, 0, 1'b0));
        send_word(cmd_word(rbfa_pkg::FUNC_RELEASE, 0, 100, 100, 0, 1'b0));
        send_word(cmd_word(rbfa_pkg::FUNC_LEFTOVER, 0, 0, 0, 4095, 1'b1));  // off head: kept
        send_word(cmd_word(rbfa_pkg::FUNC_ACQUIRE, 1, 0, 0, 0, 1'b0));      // tail wraps to 0
        send_word(cmd_word(rbfa_pkg::FUNC_RELEASE, 0, 101, 100, 0, 1'b0));  // longer than used
        send_word(cmd_word(rbfa_pkg::FUNC_RELEASE, 0, 101, 4095, 0, 1'b0)); // exactly used
    endtask

    // The spare func code, with every field at both extremes.
    task automatic test_unused_code();
        send_word(cmd_word(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 1'b1));
        send_word(cmd_word(FUNC_UNUSED, 0, 0, 0, 0, 1'b0));
    endtask

    // Random traffic. Releases mostly start at the head with a span that fits,
    // so the pointers travel round the ring. The rest is refused spans,
    // leftover moves and the spare code. Fields that an op ignores carry noise.
    task automatic test_random_traffic(input int n_words);
        rbfa_pkg::in_word_t w;
        int                 used;
        int                 len;
        for (int i = 0; i < n_words; i++)
        begin
            w.request_length = 16'($urandom);
            w.span_front     = 16'($urandom);
            w.span_rear      = 12'($urandom);
            w.new_tail       = 12'($urandom);
            w.has_data       = 1'($urandom);
            case ($urandom_range(99)) inside
                [0:39]:
                begin
                    w.func = rbfa_pkg::FUNC_ACQUIRE;
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: w.request_length = 16'($urandom_range(64));
                        6, 7:             w.request_length = 16'($urandom_range(RING_BYTES));
                        8:                ;  // full 16-bit noise
                        default:          w.request_length = 16'(contig_free_bytes());
                    endcase
                end
                [40:74]:
                begin
                    w.func = rbfa_pkg::FUNC_RELEASE;
                    used   = used_bytes();
                    if (used > 0 && $urandom_range(99) < 80)
                    begin
                        len          = ($urandom_range(3) == 0) ? used : $urandom_range(used, 1);
                        w.span_front = 16'(ring_head);
                        w.span_rear  = 12'((ring_head + len - 1) & RING_MASK);
                    end
                    else if (used < RING_BYTES && $urandom_range(1) == 1)
                    begin
                        // one byte more than is in use
                        w.span_front = 16'(ring_head);
                        w.span_rear  = 12'((ring_head + used) & RING_MASK);
                    end
                end
                [75:91]:
                begin
                    w.func = rbfa_pkg::FUNC_LEFTOVER;
                    case ($urandom_range(2))
                        0:       w.new_tail = 12'(ring_head);
                        1:       w.new_tail = 12'((ring_tail - $urandom_range(64)) & RING_MASK);
                        default: ;
                    endcase
                end
                default:
                    w.func = FUNC_UNUSED;
            endcase
            send_word(w);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: sender mostly busy, receiver mostly stalled.
        send_idle_pct = 17;
        take_idle_pct = 88;
        test_acquire_limits();
        test_release_checks();
        test_leftover_moves();
        test_unused_code();
        test_random_traffic(500);

        // Phase 2: the other way round.
        send_idle_pct = 88;
        take_idle_pct = 17;
        test_random_traffic(525);

        // Phase 3: full rate on both sides.
        send_idle_pct = 0;
        take_idle_pct = 0;
        test_random_traffic(525);

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        // Then wait on, so that any stray response word is still seen.
        repeat (5) @(posedge clk);

        if (mismatches == 0)
            $display("ring_buffer_fragment_allocator_tb OK");
        else
            $display("ring_buffer_fragment_allocator_tb NOT OK");
        $finish;
    end

    // Watchdog: ends the run as NOT OK if it has not finished by this time.
    initial
    begin
        #5_000_000;
        $display("ring_buffer_fragment_allocator_tb NOT OK");
        $finish;
    end

endmodule
